/* rtl/assert_macros.svh */
// Assertion macros for the block cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define SPN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SPN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define SPN_ASSERT(lbl, prop, msg)
`define SPN_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/spn_pkg.sv */
`default_nettype none

package spn_pkg;

    localparam int SBOX_BITS  = 4;
    localparam int SBOX_COUNT = 4;
    localparam int MAX_ROUNDS = 15;
    localparam int BLOCK_BITS = SBOX_BITS * SBOX_COUNT;

    localparam int FIELD_BITS = 16;
    localparam int TABLE_BITS = 64;
    localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
    localparam int SRC_W      = $clog2((BLOCK_BITS > 16) ? BLOCK_BITS : 16) + 1;
    localparam int POS_W      = (BLOCK_BITS > 1) ? $clog2(BLOCK_BITS) : 1;

    typedef logic [SBOX_BITS-1:0]  t_nib;
    typedef logic [BLOCK_BITS-1:0] t_block;
    typedef logic [TABLE_BITS-1:0] t_table;

    typedef enum logic [1:0] {
        CFG_CIPHER_KEY  = 2'd0,
        CFG_ROUND_COUNT = 2'd1,
        CFG_SBOX_TABLE  = 2'd2,
        CFG_PERM_TABLE  = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* rtl/spn_cell.sv */
`default_nettype none

module spn_cell
    import spn_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_nib       i_load_nib,
    input  wire t_nib       i_next_nib,
    input  wire t_nib       i_key_nib,
    input  wire t_table     i_sbox_table,
    output t_nib            o_subst
);

    t_nib r_nib;
    t_nib n_nib;

    function automatic t_nib sbox_lookup(input t_table tbl, input t_nib v);
        logic [3:0] idx;
        logic [3:0] ent;
        t_nib       res;
        idx = 4'(v);
        ent = tbl[{idx, 2'b00} +: 4];
        res = '0;
        for (int b = 0; b < SBOX_BITS; b++) begin
            if (b < 4) begin
                res[b] = ent[b];
            end
        end
        if (32'(v) >= 32'd16) begin
            res = v;
        end
        return res;
    endfunction

    always_comb begin
        priority if (i_ctrl.load) begin
            n_nib = i_load_nib;
        end else if (i_ctrl.step) begin
            n_nib = i_next_nib;
        end else begin
            n_nib = r_nib;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nib <= n_nib;
    end

    assign o_subst = sbox_lookup(i_sbox_table, r_nib ^ i_key_nib);

endmodule

`default_nettype wire

/* rtl/spn_perm.sv */
`default_nettype none

module spn_perm
    import spn_pkg::*;
(
    input  wire t_block i_block,
    input  wire t_table i_perm_table,
    output t_block      o_block
);

    // Position i counts from the most significant bit of the block.
    always_comb begin
        logic [SRC_W-1:0] src;
        o_block = '0;
        for (int i = 0; i < BLOCK_BITS; i++) begin
            if (i < 16) begin
                src = SRC_W'(i_perm_table[4*i +: 4]);
            end else begin
                src = SRC_W'(i);
            end
            if (32'(src) < BLOCK_BITS) begin
                o_block[BLOCK_BITS-1-i] = i_block[POS_W'(BLOCK_BITS - 1 - 32'(src))];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/spn_block_encrypt.sv */
`default_nettype none

// Block cipher, one 16-bit block per item, each block encrypted on its own.
// A row of S-box cells holds the block; each cycle every cell adds its key
// slice and substitutes its group, and the permutation wiring hands the bits
// back to the cells for the next round. The accepting edge loads the cells;
// each round state then steps the cell row once, and the final state writes
// the final layer into the output register. The input stays stalled until
// that write, so the block takes no new item before the last item's result
// is written. The next item is accepted in the cycle after the result is
// written, even while that result is still stalled; that item then waits in
// its final layer until the output register is free.
// The user must write configuration only while no item is in flight; the
// block itself does not enforce this.

`include "assert_macros.svh"

module spn_block_encrypt
    import spn_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_plain_block,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_cipher_block,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    logic [15:0]        r_cipher_key;
    logic [3:0]         r_round_count;
    t_table             r_sbox_table;
    t_table             r_perm_table;

    t_state             r_state;
    t_state             n_state;
    logic [ROUND_W-1:0] r_left;
    logic [ROUND_W-1:0] n_left;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [15:0]        r_cipher_block;
    logic [15:0]        n_cipher_block;

    logic               in_accept;
    logic               out_write;
    logic [ROUND_W-1:0] rounds_eff;
    t_cell_ctrl         cell_ctrl;
    t_block             key_blk;
    t_block             plain_blk;
    t_block             subst_blk;
    t_block             perm_blk;
    t_block             final_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key  <= '0;
            r_round_count <= 4'd3;
            r_sbox_table  <= 64'hFEDC_BA98_7654_3210;
            r_perm_table  <= 64'hFEDC_BA98_7654_3210;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CIPHER_KEY:  r_cipher_key  <= i_cfg_data[15:0];
                CFG_ROUND_COUNT: r_round_count <= i_cfg_data[3:0];
                CFG_SBOX_TABLE:  r_sbox_table  <= i_cfg_data;
                CFG_PERM_TABLE:  r_perm_table  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        key_blk   = '0;
        plain_blk = '0;
        for (int j = 0; j < BLOCK_BITS; j++) begin
            if (j < FIELD_BITS) begin
                key_blk[j]   = r_cipher_key[j];
                plain_blk[j] = i_plain_block[j];
            end
        end
    end

    assign rounds_eff = (32'(r_round_count) > MAX_ROUNDS) ? ROUND_W'(MAX_ROUNDS)
                                                          : ROUND_W'(r_round_count);

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_write  = (r_state == ST_FINAL) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state        = r_state;
        n_left         = r_left;
        n_out_valid    = r_out_valid && i_out_stall;
        n_cipher_block = r_cipher_block;
        cell_ctrl.load = in_accept;
        cell_ctrl.step = (r_state == ST_ROUND);
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_left  = rounds_eff;
                    n_state = (rounds_eff == '0) ? ST_FINAL : ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_left = r_left - 1'b1;
                if (r_left == ROUND_W'(1)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_write) begin
                    n_out_valid = 1'b1;
                    for (int j = 0; j < FIELD_BITS; j++) begin
                        n_cipher_block[j] = (j < BLOCK_BITS) ? final_blk[j] : 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cipher_block <= n_cipher_block;
    end

    genvar k;
    generate
        for (k = 0; k < SBOX_COUNT; k++) begin : g_cell
            localparam int SH = BLOCK_BITS - (k + 1) * SBOX_BITS;
            spn_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (cell_ctrl),
                .i_load_nib   (plain_blk[SH +: SBOX_BITS]),
                .i_next_nib   (perm_blk[SH +: SBOX_BITS]),
                .i_key_nib    (key_blk[SH +: SBOX_BITS]),
                .i_sbox_table (r_sbox_table),
                .o_subst      (subst_blk[SH +: SBOX_BITS])
            );
        end
    endgenerate

    spn_perm u_perm (
        .i_block      (subst_blk),
        .i_perm_table (r_perm_table),
        .o_block      (perm_blk)
    );

    assign final_blk = subst_blk ^ key_blk;

    assign o_out_valid    = r_out_valid;
    assign o_cipher_block = r_cipher_block;

    `SPN_ASSERT(a_accept_starts_work, in_accept |=> (r_state != ST_IDLE), "item did not start")
    `SPN_ASSERT(a_result_src, $rose(r_out_valid) |-> $past(r_state == ST_FINAL), "stray item")
    `SPN_ASSERT(a_final_write, out_write |=> (r_state == ST_IDLE) && r_out_valid, "no result")
    `SPN_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !r_out_valid && r_state == ST_IDLE, "not idle")

endmodule

`default_nettype wire

/* tb/tb_spn_block_encrypt.sv */
`timescale 1ns / 100ps

module tb_spn_block_encrypt;
    import spn_pkg::*;

    localparam int DRAIN_CYCLES = MAX_ROUNDS + 6;
    localparam int LONG_HOLD    = 80;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int PHASE_ITEMS  = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_plain_block = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_cipher_block;
    logic        i_cfg_we = 1'b0;
    t_cfg_index  i_cfg_index = CFG_CIPHER_KEY;
    logic [63:0] i_cfg_data = '0;

    // Register copies used by the predictor.
    logic [15:0] sh_key = 16'h0000;
    logic [3:0]  sh_rounds = 4'd3;
    logic [63:0] sh_sbox = 64'hFEDC_BA98_7654_3210;
    logic [63:0] sh_perm = 64'hFEDC_BA98_7654_3210;

    logic [15:0] cipher_q[$];
    logic [15:0] want_cipher;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          in_gap_pct = 0;
    int          stall_pct = 0;
    bit          long_hold_req = 1'b0;

    spn_block_encrypt dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_plain_block  (i_plain_block),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cipher_block (o_cipher_block),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("spn_block_encrypt test failed");
            $finish;
        end
    end

    function automatic t_block key_layer(t_block w);
        return w ^ t_block'(sh_key);
    endfunction

    function automatic t_block sub_layer(t_block w);
        t_block      res;
        int unsigned sh;
        int unsigned v;
        res = '0;
        for (int k = 0; k < SBOX_COUNT; k++) begin
            sh = BLOCK_BITS - (k + 1) * SBOX_BITS;
            v = (w >> sh) & ((1 << SBOX_BITS) - 1);
            if (v < 16)
                res[sh +: SBOX_BITS] = t_nib'(sh_sbox[4 * v +: 4]);
            else
                res[sh +: SBOX_BITS] = t_nib'(v);
        end
        return res;
    endfunction

    function automatic t_block perm_layer(t_block w);
        t_block      res;
        int unsigned src;
        res = '0;
        for (int i = 0; i < BLOCK_BITS; i++) begin
            src = (i < 16) ? int'(sh_perm[4 * i +: 4]) : i;
            res[BLOCK_BITS - 1 - i] = (src < BLOCK_BITS) ? w[BLOCK_BITS - 1 - src] : 1'b0;
        end
        return res;
    endfunction

    function automatic logic [15:0] predict_cipher(logic [15:0] plain);
        t_block      w;
        int unsigned rounds;
        w = t_block'(plain);
        rounds = (sh_rounds > MAX_ROUNDS) ? MAX_ROUNDS : sh_rounds;
        for (int r = 0; r < rounds; r++)
            w = perm_layer(sub_layer(key_layer(w)));
        w = key_layer(sub_layer(key_layer(w)));
        return 16'(w);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] rand_plain();
        case ($urandom_range(15))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [63:0] shuffled_nibbles();
        logic [3:0]  e[16];
        logic [3:0]  t;
        logic [63:0] r;
        int          j;
        for (int i = 0; i < 16; i++)
            e[i] = 4'(i);
        for (int i = 15; i > 0; i--) begin
            j = $urandom_range(i);
            t = e[i];
            e[i] = e[j];
            e[j] = t;
        end
        for (int i = 0; i < 16; i++)
            r[4 * i +: 4] = e[i];
        return r;
    endfunction

    // Results are checked in order as they leave the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected cipher_block %h", $time, o_cipher_block);
                mismatch_count++;
            end else begin
                want_cipher = cipher_q.pop_front();
                if (o_cipher_block !== want_cipher) begin
                    $display("%0t: cipher_block mismatch, expected %h, actual %h",
                             $time, want_cipher, o_cipher_block);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : out_stall_driver
        int n;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                n = gap_len();
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_plain(input logic [15:0] plain);
        int gap;
        gap = (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) ? gap_len() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_plain_block <= plain;
        do @(posedge i_clk); while (o_in_stall);
        cipher_q = {cipher_q, predict_cipher(plain)};
    endtask

    task automatic wait_all_ciphered();
        i_in_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_index idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] key, input logic [3:0] rounds,
                              input logic [63:0] sbox, input logic [63:0] perm);
        wait_all_ciphered();
        put_reg(CFG_CIPHER_KEY, 64'(key));
        put_reg(CFG_ROUND_COUNT, 64'(rounds));
        put_reg(CFG_SBOX_TABLE, sbox);
        put_reg(CFG_PERM_TABLE, perm);
        i_cfg_we <= 1'b0;
        sh_key = key;
        sh_rounds = rounds;
        sh_sbox = sbox;
        sh_perm = perm;
    endtask

    task automatic test_reset_defaults();
        in_gap_pct = 0;
        stall_pct = 0;
        send_plain(16'h0000);
        send_plain(16'hFFFF);
        send_plain(16'h8000);
        send_plain(16'h0001);
        send_plain(16'h1234);
    endtask

    task automatic test_directed_configs();
        set_config(16'hFFFF, 4'd0, 64'hFEDC_BA98_7654_3210, 64'hFEDC_BA98_7654_3210);
        send_plain(16'h0000);
        send_plain(16'hFFFF);
        send_plain(16'hA5A5);
        // The largest round count runs the full round limit.
        set_config(16'h3C5A, 4'd15, 64'h2174_8FE3_DA09_B65C, 64'h0123_4567_89AB_CDEF);
        send_plain(16'h0000);
        send_plain(16'hFFFF);
        send_plain(16'h0001);
        send_plain(16'h8000);
        send_plain(16'h5555);
        send_plain(16'hAAAA);
        set_config(16'h0000, 4'd1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_plain(16'h0000);
        send_plain(16'hFFFF);
        send_plain(16'h1234);
        set_config(16'h0000, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_plain(16'h0001);
        send_plain(16'hFFFE);
    endtask

    task automatic test_random_phases();
        logic [15:0] key;
        logic [3:0]  rounds;
        logic [63:0] sbox;
        logic [63:0] perm;
        for (int p = 0; p < 8; p++) begin
            case (p % 3)
                0: key = 16'h0000;
                1: key = 16'hFFFF;
                default: key = 16'($urandom_range(65535));
            endcase
            if (p == 0)
                rounds = 4'd0;
            else if (p == 1)
                rounds = 4'd15;
            else
                rounds = 4'($urandom_range(15));
            case (p % 4)
                0: sbox = shuffled_nibbles();
                1: sbox = {$urandom, $urandom};
                2: sbox = (p < 4) ? 64'h0 : 64'hFFFF_FFFF_FFFF_FFFF;
                default: sbox = shuffled_nibbles();
            endcase
            perm = ($urandom_range(3) == 0) ? {$urandom, $urandom} : shuffled_nibbles();
            set_config(key, rounds, sbox, perm);
            in_gap_pct = (p % 3) * 30;
            stall_pct = ((p + 1) % 3) * 30;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_plain(rand_plain());
        end
        in_gap_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_output_backpressure();
        set_config(16'($urandom_range(65535)), 4'd3, shuffled_nibbles(), shuffled_nibbles());
        in_gap_pct = 0;
        stall_pct = 0;
        long_hold_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_plain(rand_plain());
    endtask

    task automatic test_sender_pause();
        in_gap_pct = 40;
        stall_pct = 40;
        for (int n = 0; n < 30; n++)
            send_plain(rand_plain());
        wait_all_ciphered();
        for (int n = 0; n < 30; n++)
            send_plain(rand_plain());
        in_gap_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_configs();
        test_random_phases();
        test_output_backpressure();
        test_sender_pause();
        wait_all_ciphered();
        if (mismatch_count == 0)
            $display("spn_block_encrypt test passed");
        else
            $display("spn_block_encrypt test failed");
        $finish;
    end

endmodule
